// ===== hw/rtl/cpr_pkg.sv =====
// Shared types and constants for the clock page replacement block.
// Depends on nothing; cpr_ctrl, the top level and the testbench import it.
`timescale 1ns / 1ps

package cpr_pkg;

  localparam int unsigned ADDR_W              = 32;
  localparam int unsigned WARMUP_W            = 16;
  localparam int unsigned FRAME_W             = 2;
  localparam int unsigned EVICT_W             = 20;
  localparam int unsigned FRAMES_DEFAULT      = 4;
  localparam int unsigned OFFSET_BITS_DEFAULT = 12;

  localparam logic [WARMUP_W-1:0] WARMUP_RESET = 16'd16;
  localparam logic [WARMUP_W-1:0] COUNT_MAX    = '1;

  // One result word as it leaves the sequencer.
  typedef struct packed {
    logic               ignored;
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               evicted_valid;
    logic [EVICT_W-1:0] evicted_page;
  } cpr_result_t;

  // Start request from the front end to the sequencer.
  typedef struct packed {
    logic start;
    logic skip;
  } cpr_start_t;

endpackage

// ===== hw/rtl/cpr_page_mem.sv =====
// Page number store of the frame table: one write port, one read port
// with registered read data. Depends on nothing.
`timescale 1ns / 1ps

module cpr_page_mem #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned WIDTH = 20
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/cpr_ctrl.sv =====
// Sequencer of the clock page replacement block: frame scan, hand sweep
// and fill, with valid and reference bits. Depends on cpr_pkg.
`timescale 1ns / 1ps

module cpr_ctrl
  import cpr_pkg::*;
#(
  parameter int unsigned FRAMES = FRAMES_DEFAULT,
  parameter int unsigned PAGE_W = ADDR_W - OFFSET_BITS_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cpr_start_t                start_i,
  input  logic [PAGE_W-1:0]         page_i,
  output logic                      idle_o,
  output logic                      res_valid_o,
  input  logic                      res_take_i,
  output cpr_result_t               res_o,
  output logic [$clog2(FRAMES)-1:0] rd_addr_o,
  input  logic [PAGE_W-1:0]         rd_data_i,
  output logic                      wr_en_o,
  output logic [$clog2(FRAMES)-1:0] wr_addr_o,
  output logic [PAGE_W-1:0]         wr_data_o
);

  localparam int unsigned IDX_W = $clog2(FRAMES);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(FRAMES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP,
    ST_FILL,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [PAGE_W-1:0] page_q;
  logic [IDX_W-1:0]  scan_q;
  logic [IDX_W-1:0]  cmp_q;
  logic              cmp_vld_q;
  logic [IDX_W-1:0]  hand_q;
  logic [FRAMES-1:0] valid_q;
  logic [FRAMES-1:0] ref_q;
  cpr_result_t       res_q;

  logic             match;
  logic [IDX_W-1:0] hand_next;

  // The single comparator: read data of the previous scan address against the page.
  assign match     = cmp_vld_q && valid_q[cmp_q] && (rd_data_i == page_q);
  assign hand_next = (hand_q == LAST) ? '0 : hand_q + 1'b1;

  assign rd_addr_o = (state_q == ST_SWEEP || state_q == ST_FILL) ? hand_q : scan_q;
  assign wr_en_o   = (state_q == ST_FILL);
  assign wr_addr_o = hand_q;
  assign wr_data_o = page_q;

  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      page_q    <= '0;
      scan_q    <= '0;
      cmp_q     <= '0;
      cmp_vld_q <= 1'b0;
      hand_q    <= '0;
      valid_q   <= '0;
      ref_q     <= '0;
      res_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i.start) begin
            page_q    <= page_i;
            scan_q    <= '0;
            cmp_vld_q <= 1'b0;
            if (start_i.skip) begin
              res_q   <= cpr_result_t'{ignored: 1'b1, hit: 1'b0, frame: '0,
                                       evicted_valid: 1'b0, evicted_page: '0};
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          cmp_q     <= scan_q;
          cmp_vld_q <= 1'b1;
          if (scan_q != LAST) begin
            scan_q <= scan_q + 1'b1;
          end
          if (match) begin
            ref_q[cmp_q]        <= 1'b1;
            res_q.ignored       <= 1'b0;
            res_q.hit           <= 1'b1;
            res_q.frame         <= FRAME_W'(cmp_q);
            res_q.evicted_valid <= 1'b0;
            res_q.evicted_page  <= '0;
            state_q             <= ST_DONE;
          end else if (cmp_vld_q && cmp_q == LAST) begin
            state_q <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          // A set reference bit buys its frame a second chance.
          if (ref_q[hand_q]) begin
            ref_q[hand_q] <= 1'b0;
            hand_q        <= hand_next;
          end else begin
            state_q <= ST_FILL;
          end
        end
        ST_FILL: begin
          res_q.ignored       <= 1'b0;
          res_q.hit           <= 1'b0;
          res_q.frame         <= FRAME_W'(hand_q);
          res_q.evicted_valid <= valid_q[hand_q];
          res_q.evicted_page  <= valid_q[hand_q] ? EVICT_W'(rd_data_i) : '0;
          valid_q[hand_q]     <= 1'b1;
          ref_q[hand_q]       <= 1'b1;
          hand_q              <= hand_next;
          state_q             <= ST_DONE;
        end
        ST_DONE: begin
          if (res_take_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/clock_page_replacement.sv =====
// Top level of the clock page replacement block: warmup register, access
// counter, output register. Depends on cpr_pkg, cpr_page_mem and cpr_ctrl.
`timescale 1ns / 1ps

// Clock (second-chance) page replacement over a table of FRAMES frames.
// Each input word is a byte address; its page number is the address above
// the low OFFSET_BITS bits. The first warmup_accesses words after reset
// (counted by a 16-bit saturating counter) only produce a result with
// ignored set. After that a resident page is a hit and marks its frame
// referenced; a miss sweeps the clock hand, clearing reference bits, and
// fills the first unreferenced frame, reporting the page it replaced.
// One word is worked at a time; in_ready_o is high only while the
// sequencer is idle. An ignored word goes straight to the result; a hit
// ends the frame scan, which reads the page store one frame per cycle
// through a single comparator; a miss scans every frame, then the hand
// sweep inspects one frame per cycle and passes at most FRAMES
// referenced frames. The result sits in an output register, so the
// sequencer finishes its work while the previous result still waits to
// be taken. Configuration is written through cfg_we_i and cfg_wdata_i
// and should only change while the block is idle.
module clock_page_replacement
  import cpr_pkg::*;
#(
  parameter int unsigned FRAMES      = FRAMES_DEFAULT,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [WARMUP_W-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ADDR_W-1:0]   address_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                ignored_o,
  output logic                hit_o,
  output logic [FRAME_W-1:0]  frame_o,
  output logic                evicted_valid_o,
  output logic [EVICT_W-1:0]  evicted_page_o
);

  localparam int unsigned PAGE_W = ADDR_W - OFFSET_BITS;
  localparam int unsigned IDX_W  = $clog2(FRAMES);

  logic [WARMUP_W-1:0] warmup_q;
  logic [WARMUP_W-1:0] count_q;
  logic [WARMUP_W-1:0] count_d;
  logic                out_valid_q;
  cpr_result_t         out_res_q;

  logic        accept;
  logic        idle;
  logic        res_valid;
  logic        res_take;
  cpr_result_t res;
  cpr_start_t  start;

  logic [IDX_W-1:0]  rd_addr;
  logic [PAGE_W-1:0] rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [PAGE_W-1:0] wr_data;

  assign in_ready_o = idle;
  assign accept     = in_valid_i && idle;

  // The warmup decision uses the count before this word is counted.
  assign start.start = accept;
  assign start.skip  = (count_q < warmup_q);
  assign count_d     = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;

  // The output register takes a new result whenever it is empty or being drained.
  assign res_take = res_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warmup_q    <= WARMUP_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        warmup_q <= cfg_wdata_i;
      end
      if (accept) begin
        count_q <= count_d;
      end
      if (res_take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_res_q <= res;
    end
  end

  cpr_page_mem #(
    .DEPTH (FRAMES),
    .WIDTH (PAGE_W)
  ) u_page_mem (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  cpr_ctrl #(
    .FRAMES (FRAMES),
    .PAGE_W (PAGE_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .page_i      (address_i[ADDR_W-1:OFFSET_BITS]),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  assign out_valid_o     = out_valid_q;
  assign ignored_o       = out_res_q.ignored;
  assign hit_o           = out_res_q.hit;
  assign frame_o         = out_res_q.frame;
  assign evicted_valid_o = out_res_q.evicted_valid;
  assign evicted_page_o  = out_res_q.evicted_page;

  // An ignored word leaves the frame table untouched and reports nothing else.
  a_ignored_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ignored_o |-> !hit_o && !evicted_valid_o && frame_o == '0
                                 && evicted_page_o == '0)
    else $error("ignored result carries lookup data");

  // A hit never replaces a page.
  a_hit_no_evict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !evicted_valid_o && evicted_page_o == '0)
    else $error("hit result reports an eviction");

  // Without a replaced page the reported page number is zero.
  a_evict_page_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_valid_o |-> evicted_page_o == '0)
    else $error("evicted page set without eviction");

  // Every accepted word advances the access counter until it saturates.
  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> count_q == $past(count_d))
    else $error("access counter did not advance");

endmodule

// ===== tb/clock_page_replacement_tb.sv =====
// Self-checking testbench for the clock page replacement block: a scoreboard
// class predicts every result word. Depends on cpr_pkg and clock_page_replacement.
`timescale 1ns / 1ps

module clock_page_replacement_tb;
  import cpr_pkg::*;

  localparam int unsigned PAGE_W     = ADDR_W - OFFSET_BITS_DEFAULT;
  localparam int unsigned LIMIT      = 2_000_000;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned POOL_DEPTH = 8;
  localparam int unsigned POOL_IDX_W = $clog2(POOL_DEPTH);

  // The scoreboard keeps its own copy of the frame table, the clock hand,
  // the access counter and the warmup setting. Each accepted address word
  // is run through the replacement policy at once and the expected result
  // word is queued; result words are checked in order against that queue.
  class page_table_scoreboard;
    logic [PAGE_W-1:0]   page_tab [FRAMES_DEFAULT];
    bit                  valid_tab [FRAMES_DEFAULT];
    bit                  ref_tab [FRAMES_DEFAULT];
    int unsigned         hand;
    logic [WARMUP_W-1:0] access_count;
    logic [WARMUP_W-1:0] warmup;
    cpr_result_t         expected_q[$];
    int unsigned         errors;
    int unsigned         checked;
    int unsigned         n_ignored;
    int unsigned         n_hit;
    int unsigned         n_miss;
    int unsigned         n_evict;

    function new();
      for (int f = 0; f < FRAMES_DEFAULT; f++) begin
        page_tab[f]  = '0;
        valid_tab[f] = 1'b0;
        ref_tab[f]   = 1'b0;
      end
      hand         = 0;
      access_count = '0;
      warmup       = WARMUP_RESET;
    endfunction

    function void set_warmup(input logic [WARMUP_W-1:0] value);
      warmup = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Predict the result word of one accepted address.
    function void note_access(input logic [ADDR_W-1:0] addr);
      cpr_result_t       res;
      logic [PAGE_W-1:0] page;
      bit                skip;
      bit                found;
      int unsigned       slot;
      page  = addr[ADDR_W-1:OFFSET_BITS_DEFAULT];
      res   = '0;
      found = 1'b0;
      slot  = 0;
      // The counter advances on every word, ignored or not, and saturates.
      skip = access_count < warmup;
      if (access_count != COUNT_MAX) access_count++;
      if (skip) begin
        res.ignored = 1'b1;
        n_ignored++;
        expected_q.push_back(res);
        return;
      end
      // Only valid frames can match, so an empty frame never looks like page 0.
      for (int f = 0; f < FRAMES_DEFAULT; f++) begin
        if (!found && valid_tab[f] && page_tab[f] == page) begin
          found = 1'b1;
          slot  = f;
        end
      end
      if (found) begin
        ref_tab[slot] = 1'b1;
        n_hit++;
      end else begin
        // Second chance: clear referenced frames until an unreferenced one
        // turns up; one full turn clears them all.
        for (int s = 0; s <= FRAMES_DEFAULT; s++) begin
          if (!ref_tab[hand]) break;
          ref_tab[hand] = 1'b0;
          hand = (hand + 1) % FRAMES_DEFAULT;
        end
        slot = hand;
        if (valid_tab[slot]) begin
          res.evicted_valid = 1'b1;
          res.evicted_page  = page_tab[slot];
          n_evict++;
        end
        page_tab[slot]  = page;
        valid_tab[slot] = 1'b1;
        ref_tab[slot]   = 1'b1;
        hand = (hand + 1) % FRAMES_DEFAULT;
        n_miss++;
      end
      res.hit   = found;
      res.frame = slot[FRAME_W-1:0];
      expected_q.push_back(res);
    endfunction

    function void check_field(input string name, input longint unsigned exp_v,
                              input longint unsigned got_v);
      if (exp_v != got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
      end
    endfunction

    // Compare one accepted result word with the oldest prediction.
    function void check_result(input cpr_result_t got);
      cpr_result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, got %h", $time, got);
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      check_field("ignored", 64'(exp_r.ignored), 64'(got.ignored));
      check_field("hit", 64'(exp_r.hit), 64'(got.hit));
      check_field("frame", 64'(exp_r.frame), 64'(got.frame));
      check_field("evicted_valid", 64'(exp_r.evicted_valid), 64'(got.evicted_valid));
      check_field("evicted_page", 64'(exp_r.evicted_page), 64'(got.evicted_page));
    endfunction
  endclass

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [WARMUP_W-1:0] cfg_wdata_i     = '0;
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic [ADDR_W-1:0]   address_i       = '0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic                ignored_o;
  logic                hit_o;
  logic [FRAME_W-1:0]  frame_o;
  logic                evicted_valid_o;
  logic [EVICT_W-1:0]  evicted_page_o;

  page_table_scoreboard sb;

  // Idle rates in percent per cycle, set by the stimulus for each phase.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Flipping this asks the result side for one long hold-off.
  bit pressure_tog  = 1'b0;
  bit pressure_seen = 1'b0;
  int unsigned hold_count = 0;

  // Pages that the random addresses mostly come from, so that hits, sweeps
  // and evictions all happen often.
  logic [PAGE_W-1:0] page_pool [POOL_DEPTH];
  int unsigned       pool_size = 4;

  int unsigned cycle_count = 0;

  clock_page_replacement uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .address_i       (address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .ignored_o       (ignored_o),
    .hit_o           (hit_o),
    .frame_o         (frame_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, sb.pending());
      $display("clock_page_replacement_tb: done, errors");
      $finish;
    end
  end

  // Result side. Outputs are sampled at the edge, before the block updates,
  // so a word counts as taken exactly when valid and ready were both high.
  // Ready then follows the stall rate, or stays low through a hold-off.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_result('{ignored: ignored_o, hit: hit_o, frame: frame_o,
                          evicted_valid: evicted_valid_o, evicted_page: evicted_page_o});
      end
      if (pressure_tog != pressure_seen) begin
        pressure_seen = pressure_tog;
        hold_count    = HOLD_LEN;
      end
      if (hold_count > 0) begin
        hold_count--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one address word, with random idle cycles ahead of it, and hold it
  // until the block takes it. Valid stays high into the next word when no
  // idle cycle is drawn.
  task automatic send_word(input logic [ADDR_W-1:0] addr);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    address_i  <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_access(addr);
  endtask

  // Stop offering words and wait until every predicted result has been
  // taken, then let the block come to rest.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_warmup(input logic [WARMUP_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_warmup(value);
    cfg_we_i <= 1'b0;
  endtask

  // New page pool for a phase: the extreme pages now and then, a cluster of
  // neighbors, and fully random pages.
  task automatic fill_pool();
    logic [PAGE_W-1:0] base;
    base      = PAGE_W'($urandom());
    pool_size = $urandom_range(POOL_DEPTH, 3);
    for (int i = 0; i < POOL_DEPTH; i++) begin
      case ($urandom_range(3))
        0: begin
          page_pool[i] = ($urandom_range(1) != 0) ? '1 : '0;
        end
        1: begin
          page_pool[i] = base + PAGE_W'(i);
        end
        default: begin
          page_pool[i] = PAGE_W'($urandom());
        end
      endcase
    end
  endtask

  function automatic logic [ADDR_W-1:0] pick_address();
    logic [PAGE_W-1:0]              page;
    logic [OFFSET_BITS_DEFAULT-1:0] offset;
    logic [POOL_IDX_W-1:0]          pick;
    offset = OFFSET_BITS_DEFAULT'($urandom());
    pick   = POOL_IDX_W'($urandom_range(pool_size - 1));
    page   = page_pool[pick];
    if ($urandom_range(99) < 25) return $urandom();
    return {page, offset};
  endfunction

  task automatic run_phase(input int unsigned words, input int unsigned send_pct,
                           input int unsigned recv_pct, input bit squeeze);
    fill_pool();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (squeeze) pressure_tog <= ~pressure_tog;
    repeat (words) send_word(pick_address());
    drain();
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Warmup window at its reset length: sixteen words that change nothing,
    // among them all-zero, all-one and alternating addresses.
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'hAAAA_AAAA);
    send_word(32'h5555_5555);
    repeat (12) send_word($urandom());

    // Page 0 must miss into an empty frame, and then hit.
    send_word(32'h0000_0000);
    send_word(32'h0000_0FFF);
    // Fill the remaining empty frames, the top page among them.
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_1000);
    send_word(32'h0000_2000);
    // Every frame is referenced: the hand makes a full turn and evicts page 0.
    send_word(32'h0000_3000);
    // A hit re-marks the top page, so the next miss skips it.
    send_word(32'hFFFF_F123);
    send_word(32'h0000_0000);
    send_word(32'h0000_3ABC);
    drain();

    // Raising warmup past the counter later makes words ignored again while
    // the frame table keeps its contents.
    write_warmup(WARMUP_W'(sb.access_count + 3));
    send_word(32'h0000_0ABC);
    send_word(32'hFFFF_F000);
    send_word(32'h0000_1234);
    send_word(32'hFFFF_F000);
    send_word(32'h0000_4000);
    drain();

    // Random phases with the different idle patterns.
    write_warmup('0);
    run_phase(300, 0, 0, 1'b0);
    write_warmup(WARMUP_W'(sb.access_count + 20));
    run_phase(300, 71, 0, 1'b0);
    write_warmup('0);
    run_phase(300, 0, 71, 1'b0);
    // Long hold-off on the result side while words keep coming.
    run_phase(300, 0, 0, 1'b1);
    write_warmup(WARMUP_W'($urandom_range(sb.access_count)));
    run_phase(300, 28, 28, 1'b0);
    write_warmup(WARMUP_W'(sb.access_count + 1));
    run_phase(300, 71, 71, 1'b0);

    // Largest warmup: every further word is ignored again.
    write_warmup(COUNT_MAX);
    run_phase(40, 0, 0, 1'b0);

    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived, expected 0 left, got %0d",
               $time, sb.pending(), sb.pending());
    end
    $display("Checked %0d result words: %0d ignored, %0d hits, %0d misses with %0d evictions,",
             sb.checked, sb.n_ignored, sb.n_hit, sb.n_miss, sb.n_evict);
    $display("over warmup lengths from 0 to the counter maximum, with idle, stall and fill-up.");
    if (sb.errors == 0) begin
      $display("clock_page_replacement_tb: done, clean");
    end else begin
      $display("clock_page_replacement_tb: done, errors");
    end
    $finish;
  end

endmodule
